### sv/klock_pkg.sv
// Shared types, codes and reset constants for the keypad lock controller.
package klock_pkg;

  localparam int CODE_LENGTH_DEF = 4;
  localparam int KEY_IDX_W       = 3;
  localparam int TICK_W          = 16;
  localparam int SEC_W           = 4;
  localparam int CFG_IDX_W       = 3;

  localparam logic [TICK_W-1:0] TICK_MAX        = 16'hFFFF;
  localparam logic [SEC_W-1:0]  TIMEOUT_SECONDS = 4'd15;
  localparam logic [SEC_W-1:0]  WRONG_SECONDS   = 4'd10;

  localparam logic [31:0] SECRET_RST   = 32'd0;
  localparam logic [3:0]  TRY_LIMIT_RST = 4'd3;
  localparam logic [15:0] TIMEOUT_RST   = 16'd2000;
  localparam logic [9:0]  TPS_RST       = 10'd100;
  localparam logic [8:0]  APPROACH_RST  = 9'd10;
  localparam logic [8:0]  CLEAR_RST     = 9'd20;
  localparam logic [3:0]  ROUNDS_RST    = 4'd1;
  localparam logic [3:0]  AFTER_RST     = 4'd2;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ENTER = 2'd1,
    MODE_LOCK  = 2'd2,
    MODE_ALARM = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_KEY   = 2'd1,
    OP_RANGE = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SECRET   = 3'd0,
    REG_TRIES    = 3'd1,
    REG_TIMEOUT  = 3'd2,
    REG_TPS      = 3'd3,
    REG_APPROACH = 3'd4,
    REG_CLEAR    = 3'd5,
    REG_ROUNDS   = 3'd6,
    REG_AFTER    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] secret_code;
    logic [3:0]  try_limit;
    logic [15:0] key_timeout_ticks;
    logic [9:0]  ticks_per_second;
    logic [8:0]  approach_distance;
    logic [8:0]  clear_distance;
    logic [3:0]  lockout_rounds;
    logic [3:0]  rounds_after_alarm;
  } cfg_t;

  // one-cycle strobes, the cycle after a register write that also reloads a core counter
  typedef struct packed {
    logic load_tries;
    logic load_rounds;
  } cfg_load_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic [KEY_IDX_W-1:0] keys_entered;
    logic [3:0]           tries_left;
    logic [SEC_W-1:0]     seconds_left;
    logic                 alarm_on;
    logic                 opened;
    logic                 wrong_code;
    logic                 timed_out;
  } result_t;

endpackage

### sv/klock_cfg.sv
// Configuration register file of the keypad lock.
module klock_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [klock_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [31:0]                        wr_data,
  output klock_pkg::cfg_t                    cfg,
  output klock_pkg::cfg_load_t               load
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.secret_code        <= klock_pkg::SECRET_RST;
      cfg.try_limit          <= klock_pkg::TRY_LIMIT_RST;
      cfg.key_timeout_ticks  <= klock_pkg::TIMEOUT_RST;
      cfg.ticks_per_second   <= klock_pkg::TPS_RST;
      cfg.approach_distance  <= klock_pkg::APPROACH_RST;
      cfg.clear_distance     <= klock_pkg::CLEAR_RST;
      cfg.lockout_rounds     <= klock_pkg::ROUNDS_RST;
      cfg.rounds_after_alarm <= klock_pkg::AFTER_RST;
    end else if (wr_en) begin
      case (klock_pkg::reg_idx_t'(wr_index))
        klock_pkg::REG_SECRET:   cfg.secret_code        <= wr_data;
        klock_pkg::REG_TRIES:    cfg.try_limit          <= wr_data[3:0];
        klock_pkg::REG_TIMEOUT:  cfg.key_timeout_ticks  <= wr_data[15:0];
        klock_pkg::REG_TPS:      cfg.ticks_per_second   <= wr_data[9:0];
        klock_pkg::REG_APPROACH: cfg.approach_distance  <= wr_data[8:0];
        klock_pkg::REG_CLEAR:    cfg.clear_distance     <= wr_data[8:0];
        klock_pkg::REG_ROUNDS:   cfg.lockout_rounds     <= wr_data[3:0];
        klock_pkg::REG_AFTER:    cfg.rounds_after_alarm <= wr_data[3:0];
        default: ;
      endcase
    end
  end

  // strobe trails the write so the core reloads from the updated register
  always_ff @(posedge clk) begin
    if (rst) begin
      load.load_tries  <= 1'b0;
      load.load_rounds <= 1'b0;
    end else begin
      load.load_tries  <= wr_en && (wr_index == klock_pkg::REG_TRIES);
      load.load_rounds <= wr_en && (wr_index == klock_pkg::REG_ROUNDS);
    end
  end

endmodule

### sv/klock_core.sv
// Lock state registers and the per-word next-state logic.
module klock_core #(
  parameter int CODE_LENGTH = klock_pkg::CODE_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [1:0]           opcode,
  input  logic [7:0]           key_code,
  input  logic [8:0]           range_cm,
  input  klock_pkg::cfg_t      cfg,
  input  klock_pkg::cfg_load_t load,
  output klock_pkg::result_t   res
);

  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [klock_pkg::KEY_IDX_W-1:0] LAST_IDX =
    klock_pkg::KEY_IDX_W'(CODE_LENGTH - 1);

  klock_pkg::mode_t                   mode, mode_next;
  logic [klock_pkg::KEY_IDX_W-1:0]    key_index, key_index_next;
  logic [klock_pkg::TICK_W-1:0]       tick_count, tick_count_next, tick_inc;
  logic [3:0]                         tries, tries_next, tries_dec;
  logic [3:0]                         rounds, rounds_next;
  logic [klock_pkg::SEC_W-1:0]        seconds, seconds_next, seconds_dec;
  logic                               holding, holding_next;
  logic [7:0]                         keys [CODE_LENGTH];
  logic                               key_wr;
  logic                               match;
  logic                               opened, wrong, timed;
  logic [10:0]                        hold_ticks;

  // last key comes straight from the input word; earlier ones from storage
  always_comb begin
    logic [7:0] got;
    logic [7:0] want;
    match = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      got  = (i == CODE_LENGTH - 1) ? key_code : keys[i];
      want = 8'(cfg.secret_code >> (8 * i));
      if (got != want) match = 1'b0;
    end
  end

  always_comb begin
    tick_inc    = (tick_count == klock_pkg::TICK_MAX) ? tick_count : tick_count + 1'b1;
    tries_dec   = (tries == 4'd0) ? 4'd0 : tries - 4'd1;
    seconds_dec = (seconds == '0) ? '0 : seconds - 1'b1;
    hold_ticks  = {cfg.ticks_per_second, 1'b0};

    mode_next       = mode;
    key_index_next  = key_index;
    tick_count_next = tick_count;
    tries_next      = tries;
    rounds_next     = rounds;
    seconds_next    = seconds;
    holding_next    = holding;
    key_wr          = 1'b0;
    opened          = 1'b0;
    wrong           = 1'b0;
    timed           = 1'b0;

    if (go) begin
      case (mode)
        klock_pkg::MODE_IDLE: begin
          if (opcode == klock_pkg::OP_RANGE && range_cm <= cfg.approach_distance) begin
            mode_next       = klock_pkg::MODE_ENTER;
            key_index_next  = '0;
            tick_count_next = '0;
          end
        end
        klock_pkg::MODE_ENTER: begin
          if (opcode == klock_pkg::OP_TICK) begin
            tick_count_next = tick_inc;
            if (tick_inc >= cfg.key_timeout_ticks) begin
              timed           = 1'b1;
              mode_next       = klock_pkg::MODE_LOCK;
              key_index_next  = '0;
              tick_count_next = '0;
              seconds_next    = klock_pkg::TIMEOUT_SECONDS;
            end
          end else if (opcode == klock_pkg::OP_KEY) begin
            key_wr          = 1'b1;
            tick_count_next = '0;
            if (key_index == LAST_IDX) begin
              key_index_next = '0;
              if (match) begin
                opened    = 1'b1;
                mode_next = klock_pkg::MODE_IDLE;
              end else begin
                wrong      = 1'b1;
                tries_next = tries_dec;
                if (tries_dec != 4'd0) begin
                  mode_next = klock_pkg::MODE_ENTER;
                end else if (rounds != 4'd0) begin
                  rounds_next  = rounds - 4'd1;
                  mode_next    = klock_pkg::MODE_LOCK;
                  seconds_next = klock_pkg::WRONG_SECONDS;
                end else begin
                  mode_next    = klock_pkg::MODE_ALARM;
                  holding_next = 1'b0;
                end
              end
            end else begin
              key_index_next = key_index + 1'b1;
            end
          end
        end
        klock_pkg::MODE_LOCK: begin
          if (opcode == klock_pkg::OP_TICK) begin
            tick_count_next = tick_inc;
            if (tick_inc >= 16'(cfg.ticks_per_second)) begin
              tick_count_next = '0;
              seconds_next    = seconds_dec;
              if (seconds_dec == '0) begin
                tries_next     = cfg.try_limit;
                mode_next      = klock_pkg::MODE_ENTER;
                key_index_next = '0;
              end
            end
          end
        end
        klock_pkg::MODE_ALARM: begin
          if (!holding) begin
            if (opcode == klock_pkg::OP_RANGE && range_cm > cfg.clear_distance) begin
              holding_next    = 1'b1;
              tick_count_next = '0;
            end
          end else if (opcode == klock_pkg::OP_TICK) begin
            tick_count_next = tick_inc;
            if (tick_inc >= 16'(hold_ticks)) begin
              holding_next    = 1'b0;
              tick_count_next = '0;
              rounds_next     = cfg.rounds_after_alarm;
              tries_next      = cfg.try_limit;
              mode_next       = klock_pkg::MODE_IDLE;
            end
          end
        end
        default: ;
      endcase
    end

    res.mode         = mode_next;
    res.keys_entered = key_index_next;
    res.tries_left   = tries_next;
    res.seconds_left = (mode_next == klock_pkg::MODE_LOCK) ? seconds_next : '0;
    res.alarm_on     = (mode_next == klock_pkg::MODE_ALARM);
    res.opened       = opened;
    res.wrong_code   = wrong;
    res.timed_out    = timed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= klock_pkg::MODE_IDLE;
      key_index  <= '0;
      tick_count <= '0;
      tries      <= klock_pkg::TRY_LIMIT_RST;
      rounds     <= klock_pkg::ROUNDS_RST;
      seconds    <= '0;
      holding    <= 1'b0;
    end else begin
      mode       <= mode_next;
      key_index  <= key_index_next;
      tick_count <= tick_count_next;
      seconds    <= seconds_next;
      holding    <= holding_next;
      // register writes must come only while idle (not enforced); a reload wins;
      // the strobe trails the write, so the register already holds the new value
      tries      <= load.load_tries  ? cfg.try_limit      : tries_next;
      rounds     <= load.load_rounds ? cfg.lockout_rounds : rounds_next;
    end
  end

  // key storage: no reset, every slot is written before it is compared
  always_ff @(posedge clk) begin
    if (key_wr) keys[key_index[IDX_W-1:0]] <= key_code;
  end

endmodule

### sv/keypad_lock_with_lockout.sv
// Top level of the keypad combination lock with lockout and alarm.
//
// Lock controller fed one event word at a time (timer tick, key press or
// distance sample) on the input channel; every accepted word yields exactly
// one result word giving the lock state after that event plus the opened,
// wrong-code and timed-out pulses. Throughput is one word per clock while
// out_ready holds high. A word waits in the input register until the core's
// next-state logic updates the state and loads the output register, which
// then raises out_valid for its result word. The output register
// stalls on out_ready low while the input register can still take one more
// word. Configuration words go in over the cfg channel (always ready) and must
// be written while the lock is quiet; writing try_limit or lockout_rounds also
// reloads the live try or round counter in the cycle after the write.
// CODE_LENGTH sets how many keys make one entry.
module keypad_lock_with_lockout #(
  parameter int CODE_LENGTH = klock_pkg::CODE_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // event words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  key_code,
  input  logic [8:0]  range_cm,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  mode,
  output logic [2:0]  keys_entered,
  output logic [3:0]  tries_left,
  output logic [3:0]  seconds_left,
  output logic        alarm_on,
  output logic        opened,
  output logic        wrong_code,
  output logic        timed_out,
  // configuration words
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  klock_pkg::cfg_t      cfg;
  klock_pkg::cfg_load_t load;
  klock_pkg::result_t   res_next;
  klock_pkg::result_t   res;

  // input register
  logic       in_full;
  logic [1:0] op_q;
  logic [7:0] key_q;
  logic [8:0] range_q;
  logic       go;

  // a held word moves on whenever the output register is free or draining
  assign go        = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || go;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q    <= opcode;
      key_q   <= key_code;
      range_q <= range_cm;
    end
  end

  klock_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .load     (load)
  );

  klock_core #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .opcode   (op_q),
    .key_code (key_q),
    .range_cm (range_q),
    .cfg      (cfg),
    .load     (load),
    .res      (res_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) res <= res_next;
  end

  assign mode         = res.mode;
  assign keys_entered = res.keys_entered;
  assign tries_left   = res.tries_left;
  assign seconds_left = res.seconds_left;
  assign alarm_on     = res.alarm_on;
  assign opened       = res.opened;
  assign wrong_code   = res.wrong_code;
  assign timed_out    = res.timed_out;

endmodule

### tb/sv/keypad_lock_with_lockout_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the keypad lock: directed cases, then random event streams.
module keypad_lock_with_lockout_test;

  localparam logic [1:0] OP_SPARE = 2'd3;   // undefined opcode, must be ignored
  localparam int HOLD_SECONDS = 2;          // alarm stays on this long after walk-away
  localparam int SETTLE_CYCLES = 4;         // two-stage pipe plus margin
  localparam int MAX_SHOWN = 10;
  localparam int TIMEOUT_NS = 1_000_000;    // far above any good run
  localparam int PHASE_WORDS = 430;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = '0;
  logic [7:0]  key_code = '0;
  logic [8:0]  range_cm = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  mode;
  logic [2:0]  keys_entered;
  logic [3:0]  tries_left;
  logic [3:0]  seconds_left;
  logic        alarm_on;
  logic        opened;
  logic        wrong_code;
  logic        timed_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  keypad_lock_with_lockout u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .key_code     (key_code),
    .range_cm     (range_cm),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mode         (mode),
    .keys_entered (keys_entered),
    .tries_left   (tries_left),
    .seconds_left (seconds_left),
    .alarm_on     (alarm_on),
    .opened       (opened),
    .wrong_code   (wrong_code),
    .timed_out    (timed_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Lock model: our own copy of the registers and of the controller state.
  // ---------------------------------------------------------------------------
  klock_pkg::cfg_t  lock_cfg;
  klock_pkg::mode_t lk_mode;
  logic [7:0]  typed_keys [klock_pkg::CODE_LENGTH_DEF];
  logic [2:0]  key_pos;
  logic [15:0] tick_cnt;
  logic [3:0]  tries;
  logic [3:0]  rounds;
  logic [3:0]  secs;
  logic        holding;
  bit          aim_right;    // random entry in progress is meant to be the right code

  klock_pkg::result_t status_due [$];   // lock status words still owed by the block
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  function automatic void reset_model();
    lock_cfg.secret_code        = klock_pkg::SECRET_RST;
    lock_cfg.try_limit          = klock_pkg::TRY_LIMIT_RST;
    lock_cfg.key_timeout_ticks  = klock_pkg::TIMEOUT_RST;
    lock_cfg.ticks_per_second   = klock_pkg::TPS_RST;
    lock_cfg.approach_distance  = klock_pkg::APPROACH_RST;
    lock_cfg.clear_distance     = klock_pkg::CLEAR_RST;
    lock_cfg.lockout_rounds     = klock_pkg::ROUNDS_RST;
    lock_cfg.rounds_after_alarm = klock_pkg::AFTER_RST;
    lk_mode  = klock_pkg::MODE_IDLE;
    foreach (typed_keys[i]) typed_keys[i] = '0;
    key_pos  = '0;
    tick_cnt = '0;
    tries    = klock_pkg::TRY_LIMIT_RST;
    rounds   = klock_pkg::ROUNDS_RST;
    secs     = '0;
    holding  = 1'b0;
  endfunction

  // register write as the block sees it: data cut to width, some writes reload counters
  function automatic void apply_reg(klock_pkg::reg_idx_t idx, logic [31:0] d);
    case (idx)
      klock_pkg::REG_SECRET:   lock_cfg.secret_code = d;
      klock_pkg::REG_TRIES: begin
        lock_cfg.try_limit = d[3:0];
        tries = d[3:0];
      end
      klock_pkg::REG_TIMEOUT:  lock_cfg.key_timeout_ticks = d[15:0];
      klock_pkg::REG_TPS:      lock_cfg.ticks_per_second = d[9:0];
      klock_pkg::REG_APPROACH: lock_cfg.approach_distance = d[8:0];
      klock_pkg::REG_CLEAR:    lock_cfg.clear_distance = d[8:0];
      klock_pkg::REG_ROUNDS: begin
        lock_cfg.lockout_rounds = d[3:0];
        rounds = d[3:0];
      end
      klock_pkg::REG_AFTER:    lock_cfg.rounds_after_alarm = d[3:0];
      default: ;
    endcase
  endfunction

  function automatic void begin_entry();
    lk_mode  = klock_pkg::MODE_ENTER;
    key_pos  = '0;
    tick_cnt = '0;
  endfunction

  function automatic void begin_lockout(logic [3:0] s);
    lk_mode  = klock_pkg::MODE_LOCK;
    key_pos  = '0;
    tick_cnt = '0;
    secs     = s;
  endfunction

  function automatic void bump_ticks();
    if (tick_cnt != klock_pkg::TICK_MAX) tick_cnt++;
  endfunction

  function automatic bit code_ok();
    int i;
    for (i = 0; i < klock_pkg::CODE_LENGTH_DEF; i++)
      if (typed_keys[i] != lock_cfg.secret_code[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // Advance the model by one event word and return the status word it must produce.
  function automatic klock_pkg::result_t next_lock_status(logic [1:0] op, logic [7:0] key,
                                                          logic [8:0] dist_cm);
    klock_pkg::result_t r;
    r = '0;
    case (lk_mode)
      klock_pkg::MODE_IDLE: begin
        if (op == klock_pkg::OP_RANGE && dist_cm <= lock_cfg.approach_distance) begin
          begin_entry();
        end
      end
      klock_pkg::MODE_ENTER: begin
        if (op == klock_pkg::OP_TICK) begin
          bump_ticks();
          if (tick_cnt >= lock_cfg.key_timeout_ticks) begin
            r.timed_out = 1'b1;
            begin_lockout(klock_pkg::TIMEOUT_SECONDS);
          end
        end else if (op == klock_pkg::OP_KEY) begin
          if (key_pos < klock_pkg::CODE_LENGTH_DEF) typed_keys[int'(key_pos)] = key;
          key_pos++;
          tick_cnt = '0;
          if (key_pos >= klock_pkg::CODE_LENGTH_DEF) begin
            key_pos = '0;
            if (code_ok()) begin
              r.opened = 1'b1;
              lk_mode = klock_pkg::MODE_IDLE;
            end else begin
              r.wrong_code = 1'b1;
              if (tries != 0) tries--;
              if (tries != 0) begin
                begin_entry();
              end else if (rounds != 0) begin
                rounds--;
                begin_lockout(klock_pkg::WRONG_SECONDS);
              end else begin
                lk_mode  = klock_pkg::MODE_ALARM;
                holding  = 1'b0;
                tick_cnt = '0;
              end
            end
          end
        end
      end
      klock_pkg::MODE_LOCK: begin
        if (op == klock_pkg::OP_TICK) begin
          bump_ticks();
          if (tick_cnt >= {6'd0, lock_cfg.ticks_per_second}) begin
            tick_cnt = '0;
            if (secs != 0) secs--;
            if (secs == 0) begin
              tries = lock_cfg.try_limit;
              begin_entry();
            end
          end
        end
      end
      klock_pkg::MODE_ALARM: begin
        if (!holding) begin
          if (op == klock_pkg::OP_RANGE && dist_cm > lock_cfg.clear_distance) begin
            holding  = 1'b1;
            tick_cnt = '0;
          end
        end else if (op == klock_pkg::OP_TICK) begin
          bump_ticks();
          if ({1'b0, tick_cnt} >= 17'(HOLD_SECONDS * lock_cfg.ticks_per_second)) begin
            holding  = 1'b0;
            tick_cnt = '0;
            rounds   = lock_cfg.rounds_after_alarm;
            tries    = lock_cfg.try_limit;
            lk_mode  = klock_pkg::MODE_IDLE;
          end
        end
      end
      default: ;
    endcase
    r.mode         = lk_mode;
    r.keys_entered = key_pos;
    r.tries_left   = tries;
    r.seconds_left = (lk_mode == klock_pkg::MODE_LOCK) ? secs : '0;
    r.alarm_on     = (lk_mode == klock_pkg::MODE_ALARM);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, receiver back-pressure and watchdog.
  // ---------------------------------------------------------------------------
  initial forever #1 clk = ~clk;

  // random stall on the result side; zero percent means always ready
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  initial begin
    #(TIMEOUT_NS);
    $display("** keypad_lock_with_lockout: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result checking: every accepted status word against the oldest one owed.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("%0t: %s mismatch, expected %0d got %0d", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    klock_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: status word with none outstanding", $realtime);
      end else begin
        want = status_due.pop_front();
        check_field("mode", 32'(want.mode), 32'(mode));
        check_field("keys_entered", 32'(want.keys_entered), 32'(keys_entered));
        check_field("tries_left", 32'(want.tries_left), 32'(tries_left));
        check_field("seconds_left", 32'(want.seconds_left), 32'(seconds_left));
        check_field("alarm_on", 32'(want.alarm_on), 32'(alarm_on));
        check_field("opened", 32'(want.opened), 32'(opened));
        check_field("wrong_code", 32'(want.wrong_code), 32'(wrong_code));
        check_field("timed_out", 32'(want.timed_out), 32'(timed_out));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Inputs move on the falling edge; handshakes are seen on the rising one.
  // ---------------------------------------------------------------------------

  // One event word; valid stays up across back-to-back words and only drops for a gap.
  task automatic send_event(logic [1:0] op, logic [7:0] key, logic [8:0] dist_cm);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    opcode   = op;
    key_code = key;
    range_cm = dist_cm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    status_due.push_back(next_lock_status(op, key, dist_cm));
  endtask

  // Stop sending and wait for every owed status word, then let the pipe settle.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; callers drain first so the lock is quiet.
  task automatic write_reg(klock_pkg::reg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Four key presses, first key from the low byte.
  task automatic press_code(logic [31:0] keys32);
    int i;
    for (i = 0; i < klock_pkg::CODE_LENGTH_DEF; i++)
      send_event(klock_pkg::OP_KEY, keys32[8*i +: 8], 9'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests.
  // ---------------------------------------------------------------------------

  // An idle lock reacts only to a close-range sample.
  task automatic test_ignored_in_idle();
    send_event(klock_pkg::OP_TICK, 8'hFF, 9'h1FF);
    send_event(klock_pkg::OP_KEY, 8'hFF, 9'h000);
    send_event(OP_SPARE, 8'hFF, 9'h1FF);
    send_event(klock_pkg::OP_RANGE, 8'h00, klock_pkg::APPROACH_RST + 9'd1);   // one cm too far
    send_event(klock_pkg::OP_RANGE, 8'h00, 9'h1FF);
  endtask

  // Sample right at the approach distance wakes it; the code out of reset is all-zero keys.
  task automatic test_open_with_reset_code();
    send_event(klock_pkg::OP_RANGE, 8'hFF, klock_pkg::APPROACH_RST);
    press_code(klock_pkg::SECRET_RST);
  endtask

  // One try and no rounds: a wrong entry trips the alarm, walking away clears it.
  task automatic test_wrong_entry_alarm();
    drain_results();
    write_reg(klock_pkg::REG_TRIES, 32'd1);
    write_reg(klock_pkg::REG_ROUNDS, 32'd0);
    write_reg(klock_pkg::REG_TPS, 32'd0);      // zero limit: hold ends on the first counted tick
    write_reg(klock_pkg::REG_CLEAR, 32'd0);
    send_event(klock_pkg::OP_RANGE, 8'h00, 9'h000);
    press_code(32'hFFFF_FFFF);
    send_event(klock_pkg::OP_RANGE, 8'h00, 9'h000);   // still within clear distance
    send_event(klock_pkg::OP_TICK, 8'h00, 9'h000);    // ticks don't count before the hold
    send_event(klock_pkg::OP_RANGE, 8'h00, 9'h001);   // walked away, hold starts
    send_event(klock_pkg::OP_TICK, 8'h00, 9'h000);
  endtask

  // Zero key timeout: the first tick while entering starts the long lockout.
  task automatic test_key_timeout();
    drain_results();
    write_reg(klock_pkg::REG_TIMEOUT, 32'd0);
    write_reg(klock_pkg::REG_APPROACH, 32'd0);
    send_event(klock_pkg::OP_RANGE, 8'h00, 9'h000);
    send_event(klock_pkg::OP_TICK, 8'h00, 9'h000);
    send_event(klock_pkg::OP_KEY, 8'h5A, 9'h000);     // keys are dead during lockout
    send_event(klock_pkg::OP_TICK, 8'h00, 9'h000);    // one second per tick at zero rate
  endtask

  // Zero writes to two registers, then all-ones to every one; narrow ones keep only their low bits.
  task automatic test_register_extremes();
    drain_results();
    write_reg(klock_pkg::REG_TRIES, 32'd0);
    write_reg(klock_pkg::REG_AFTER, 32'd0);
    write_reg(klock_pkg::REG_SECRET, 32'hFFFF_FFFF);
    write_reg(klock_pkg::REG_TRIES, 32'hFFFF_FFFF);
    write_reg(klock_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(klock_pkg::REG_TPS, 32'hFFFF_FFFF);
    write_reg(klock_pkg::REG_APPROACH, 32'hFFFF_FFFF);
    write_reg(klock_pkg::REG_CLEAR, 32'hFFFF_FFFF);
    write_reg(klock_pkg::REG_ROUNDS, 32'hFFFF_FFFF);
    write_reg(klock_pkg::REG_AFTER, 32'hFFFF_FFFF);
    send_event(klock_pkg::OP_TICK, 8'hFF, 9'h1FF);    // lockout now counts toward 1023
    send_event(klock_pkg::OP_RANGE, 8'hFF, 9'h000);
  endtask

  // ---------------------------------------------------------------------------
  // Random streams, steered by the model's state so entries, lockouts and
  // alarms are reached often; a share of every mode's words is plain noise.
  // ---------------------------------------------------------------------------
  task automatic pick_event(output logic [1:0] op, output logic [7:0] key,
                            output logic [8:0] dist_cm);
    int roll;
    roll    = $urandom_range(99);
    op      = 2'($urandom);
    key     = 8'($urandom);
    dist_cm = 9'($urandom);
    case (lk_mode)
      klock_pkg::MODE_IDLE: begin
        if (roll < 80) begin
          op      = klock_pkg::OP_RANGE;
          dist_cm = 9'($urandom_range(0, lock_cfg.approach_distance));
        end
      end
      klock_pkg::MODE_ENTER: begin
        if (roll < 65) begin
          op = klock_pkg::OP_KEY;
          if (key_pos == 0) aim_right = ($urandom_range(1) == 0);
          if (aim_right) key = lock_cfg.secret_code[8*key_pos +: 8];
        end else if (roll < 90) begin
          op = klock_pkg::OP_TICK;
        end
      end
      klock_pkg::MODE_LOCK: begin
        if (roll < 85) op = klock_pkg::OP_TICK;
      end
      klock_pkg::MODE_ALARM: begin
        if (holding) begin
          if (roll < 85) op = klock_pkg::OP_TICK;
        end else if (roll < 35 && lock_cfg.clear_distance < 9'h1FF) begin
          op      = klock_pkg::OP_RANGE;
          dist_cm = 9'($urandom_range(lock_cfg.clear_distance + 1, 511));
        end else if (roll < 70) begin
          op = klock_pkg::OP_RANGE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic run_random_phase(int send_pct, int stall_pct, int target);
    int         sent_n;
    logic [1:0] op;
    logic [7:0] key;
    logic [8:0] dist_cm;
    drain_results();
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    // small limits keep timeouts and countdowns short enough to hit many times
    write_reg(klock_pkg::REG_SECRET, $urandom);
    write_reg(klock_pkg::REG_TRIES, $urandom_range(0, 5));
    write_reg(klock_pkg::REG_TIMEOUT, $urandom_range(0, 40));
    write_reg(klock_pkg::REG_TPS, $urandom_range(0, 4));
    write_reg(klock_pkg::REG_APPROACH, $urandom_range(0, 511));
    write_reg(klock_pkg::REG_CLEAR, $urandom_range(0, 510));   // 511 would never let the alarm end
    write_reg(klock_pkg::REG_ROUNDS, $urandom_range(0, 15));
    write_reg(klock_pkg::REG_AFTER, $urandom_range(0, 15));
    for (sent_n = 0; sent_n < target; sent_n++) begin
      pick_event(op, key, dist_cm);
      send_event(op, key, dist_cm);
      // mid-phase, hold the sender off until the lock has answered everything
      if (sent_n == target / 2) drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_ignored_in_idle();
    test_open_with_reset_code();
    test_wrong_entry_alarm();
    test_key_timeout();
    test_register_extremes();

    run_random_phase(0, 0, PHASE_WORDS);     // full rate both ways
    run_random_phase(45, 0, PHASE_WORDS);    // sender gaps
    run_random_phase(0, 45, PHASE_WORDS);    // receiver stalls
    run_random_phase(23, 23, PHASE_WORDS);   // both

    drain_results();
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("** keypad_lock_with_lockout: PASSED **");
    end else begin
      $display("** keypad_lock_with_lockout: FAILED **");
    end
    $finish;
  end

endmodule
